/* hw/rtl/uudec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uudec_pkg
// Shared types and constants for the uu-style line decoder.
// ----------------------------------------------------------------------------
package uudec_pkg;

	// result queue geometry
	localparam int unsigned Q_DEPTH = 8;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// most results one character can cause
	localparam int unsigned MAX_RES = 3;

	// character codes and offset values
	localparam logic [6:0] CH_NEWLINE = 7'd10;
	localparam logic [6:0] CH_OFFSET  = 7'd64;
	localparam logic [6:0] LEN_E      = 7'd37;  // 'e' - 64
	localparam logic [5:0] SX_N       = 6'd46;  // 'n' - 64
	localparam logic [5:0] SX_D       = 6'd36;  // 'd' - 64

	typedef struct packed {
		logic [7:0] byte_out;
		logic       line_last;
		logic       end_marker;
		logic       run_last;
	} uudec_res_t;

endpackage : uudec_pkg
`default_nettype wire

/* hw/rtl/uu_style_line_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uu_style_line_decoder_unit
// Decodes a uu-style text stream, one 7-bit character per item, into bytes
// with line and end flags.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid, in_ready  | char_in[6:0]
//  out     | out_valid, out_ready| byte_out[7:0], line_last, end_marker,
//          |                     | run_last
//
//  One character is accepted per cycle while in_ready is high. An accepted
//  character sits in the stage-1 register and is decoded there, pushing
//  0 to 3 results into an 8-entry result queue; results leave the queue
//  on out one per cycle while out_ready is high.
//  in_ready drops only while stage 1 holds a character and the queue has
//  fewer than three free entries.
//  Reset (arst_n low) returns to header skipping and empties the queue.
// ----------------------------------------------------------------------------
module uu_style_line_decoder_unit
	import uudec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [6:0] char_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      byte_out,
	output logic            line_last,
	output logic            end_marker,
	output logic            run_last
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_GROUPS,
		PH_DONE
	} phase_t;

	// stage 1
	logic       valid_s1;
	logic [6:0] char_s1;

	// decoder state
	phase_t     phase_q,       phase_d;
	logic [6:0] bytes_left_q,  bytes_left_d;
	logic [1:0] char_index_q,  char_index_d;
	logic [5:0] held_q [3];
	logic [5:0] held_d [3];
	logic       first_group_q, first_group_d;
	logic       length_is_e_q, length_is_e_d;

	// result queue
	uudec_res_t           queue_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic [Q_PTR_W-1:0]   wr_idx [MAX_RES];

	logic       advance;
	logic       pop;
	logic [1:0] push_n;
	uudec_res_t res [MAX_RES];

	logic [6:0] len_val;
	logic [5:0] sextet;
	logic [1:0] take;
	logic [7:0] grp_byte [MAX_RES];

	assign advance  = valid_s1 && (count_q <= Q_CNT_W'(Q_DEPTH - MAX_RES));
	assign in_ready = !valid_s1 || advance;
	assign pop      = out_valid && out_ready;

	assign out_valid  = (count_q != '0);
	assign byte_out   = queue_q[rd_ptr_q].byte_out;
	assign line_last  = queue_q[rd_ptr_q].line_last;
	assign end_marker = queue_q[rd_ptr_q].end_marker;
	assign run_last   = queue_q[rd_ptr_q].run_last;

	assign len_val = (char_s1 > CH_OFFSET) ? (char_s1 - CH_OFFSET) : char_s1;
	assign sextet  = char_s1[5:0];  // drop 64 when set
	assign take    = (bytes_left_q < 7'd3) ? bytes_left_q[1:0] : 2'd3;

	assign grp_byte[0] = {held_q[0], held_q[1][5:4]};
	assign grp_byte[1] = {held_q[1][3:0], held_q[2][5:2]};
	assign grp_byte[2] = {held_q[2][1:0], sextet};

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		char_index_d  = char_index_q;
		first_group_d = first_group_q;
		length_is_e_d = length_is_e_q;
		for (int i = 0; i < MAX_RES; i++) begin
			held_d[i] = held_q[i];
			res[i]    = '0;
		end
		push_n = 2'd0;

		case (phase_q)
			PH_HEADER: begin
				if (char_s1 == CH_NEWLINE) begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (char_s1 == CH_NEWLINE && char_index_q == 2'd0) begin
					char_index_d = 2'd1;
				end else begin
					char_index_d = 2'd0;
					if (len_val != 7'd0) begin
						bytes_left_d  = len_val;
						length_is_e_d = (len_val == LEN_E);
						first_group_d = 1'b1;
						phase_d       = PH_GROUPS;
					end
				end
			end
			PH_GROUPS: begin
				if (char_index_q != 2'd3) begin
					if (char_index_q == 2'd1 && first_group_q && length_is_e_q &&
					    held_q[0] == SX_N && sextet == SX_D) begin
						phase_d           = PH_DONE;
						res[0].end_marker = 1'b1;
						res[0].run_last   = 1'b1;
						push_n            = 2'd1;
					end else begin
						held_d[char_index_q] = sextet;
						char_index_d         = char_index_q + 2'd1;
					end
				end else begin
					char_index_d  = 2'd0;
					first_group_d = 1'b0;
					bytes_left_d  = bytes_left_q - {5'd0, take};
					push_n        = take;
					for (int k = 0; k < MAX_RES; k++) begin
						res[k].byte_out  = grp_byte[k];
						res[k].run_last  = (2'(k) == take - 2'd1);
						res[k].line_last = (2'(k) == take - 2'd1) && (bytes_left_d == 7'd0);
					end
					if (bytes_left_d == 7'd0) begin
						phase_d = PH_LENGTH;
					end
				end
			end
			PH_DONE: begin
				// ignore everything after the end line
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < MAX_RES; k++) begin
			wr_idx[k] = wr_ptr_q + Q_PTR_W'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			phase_q       <= PH_HEADER;
			bytes_left_q  <= '0;
			char_index_q  <= '0;
			first_group_q <= 1'b0;
			length_is_e_q <= 1'b0;
			for (int i = 0; i < MAX_RES; i++) begin
				held_q[i] <= '0;
			end
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			count_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q       <= phase_d;
				bytes_left_q  <= bytes_left_d;
				char_index_q  <= char_index_d;
				first_group_q <= first_group_d;
				length_is_e_q <= length_is_e_d;
				for (int i = 0; i < MAX_RES; i++) begin
					held_q[i] <= held_d[i];
				end
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + (advance ? Q_CNT_W'(push_n) : '0)
			           - Q_CNT_W'(pop);
		end
	end

	// payload: char and queue entries need no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
		if (advance) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (2'(k) < push_n) begin
					queue_q[wr_idx[k]] <= res[k];
				end
			end
		end
	end

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue count above depth");

	// nothing is pushed once the end line was seen
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (!advance || push_n == 2'd0))
		else $error("result pushed after end line");

	// an end result always moves the decoder to its final phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && push_n != 2'd0 && res[0].end_marker) |=> (phase_q == PH_DONE))
		else $error("end result without final phase");

endmodule : uu_style_line_decoder_unit
`default_nettype wire
